@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, including those during reset.
`define SFSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every rising edge outside reset.
`define SFSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ sv/sfsc_pkg.sv @@
package sfsc_pkg;

  localparam int TEMP_W     = 8;
  localparam int DUTY_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int unsigned PWM_PERIOD_DEF = 50;

  localparam logic [DUTY_W-1:0] KICK_DUTY  = DUTY_W'(45);
  localparam logic [DUTY_W-1:0] FAULT_DUTY = DUTY_W'(49);
  localparam int                HYST       = 2;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_BAND1_TEMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND2_TEMP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND3_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND1_DUTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND2_DUTY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND3_DUTY = 3'd6;

  localparam logic [TEMP_W-1:0] BAND1_TEMP_RST = 8'd30;
  localparam logic [TEMP_W-1:0] BAND2_TEMP_RST = 8'd45;
  localparam logic [TEMP_W-1:0] BAND3_TEMP_RST = 8'd60;
  localparam logic [TEMP_W-1:0] ALARM_TEMP_RST = 8'd75;
  localparam logic [DUTY_W-1:0] BAND1_DUTY_RST = 6'd10;
  localparam logic [DUTY_W-1:0] BAND2_DUTY_RST = 6'd25;
  localparam logic [DUTY_W-1:0] BAND3_DUTY_RST = 6'd48;

  // Item kinds.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage

@@ sv/sfsc_if.sv @@
interface sfsc_item_if;
  import sfsc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [TEMP_W-1:0] temp_reading;
  logic              sensor_fault;
  modport source (output valid, output op, output temp_reading, output sensor_fault,
                  input ready);
  modport sink (input valid, input op, input temp_reading, input sensor_fault,
                output ready);
endinterface

interface sfsc_result_if;
  import sfsc_pkg::*;
  logic              valid;
  logic              ready;
  logic              fan_on;
  logic [DUTY_W-1:0] duty_now;
  logic              alarm_on;
  modport source (output valid, output fan_on, output duty_now, output alarm_on,
                  input ready);
  modport sink (input valid, input fan_on, input duty_now, input alarm_on,
                output ready);
endinterface

interface sfsc_cfg_if;
  import sfsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/stepped_fan_speed_controller_core.sv @@
// Stepped fan controller. Each request is either a PWM tick (op 0) or a temperature
// sample (op 1) and gives exactly one result with the fan level, the duty in force and
// the buzzer level. Requests are taken into an input register, evaluated by a single pass
// of compare logic against the current state and the result register, so one request is
// accepted every cycle while the result side keeps up; its result passes the input and
// then the result register. The input register frees itself whenever the result register
// can take a new value, so a waiting result stalls new requests only once the input
// register is full. Bands select band1..band3 duty with a 2-degree hysteresis on the way
// down, the first sample after the fan stopped gives a kick duty of 45, a faulty sensor
// forces duty 49, and a tick steps a counter of PWM_PERIOD steps. Configuration writes
// are always accepted and should only be issued while no request is in flight.
module stepped_fan_speed_controller_core #(
  parameter int unsigned PWM_PERIOD = sfsc_pkg::PWM_PERIOD_DEF
) (
  input logic           clk,
  input logic           rst,
  sfsc_cfg_if.sink      cfg,
  sfsc_item_if.sink     item,
  sfsc_result_if.source result
);
  import sfsc_pkg::*;

  localparam int CNT_W = $clog2(PWM_PERIOD);
  localparam int CMP_W = (CNT_W > DUTY_W) ? CNT_W : DUTY_W;
  localparam int EXT_W = TEMP_W + 1;

  // Configuration registers.
  logic [TEMP_W-1:0] band1_temp;
  logic [TEMP_W-1:0] band2_temp;
  logic [TEMP_W-1:0] band3_temp;
  logic [TEMP_W-1:0] alarm_temp;
  logic [DUTY_W-1:0] band1_duty;
  logic [DUTY_W-1:0] band2_duty;
  logic [DUTY_W-1:0] band3_duty;

  // Controller state.
  logic [DUTY_W-1:0] band_duty;
  logic              fan_running;
  logic [DUTY_W-1:0] duty_level;
  logic [CNT_W-1:0]  pwm_count;
  logic              alarm_flag;
  logic              fan_level;

  logic [DUTY_W-1:0] band_duty_next;
  logic              fan_running_next;
  logic [DUTY_W-1:0] duty_level_next;
  logic [CNT_W-1:0]  pwm_count_next;
  logic              alarm_flag_next;
  logic              fan_level_next;

  // Input register.
  logic              in_valid;
  logic              in_op;
  logic [TEMP_W-1:0] in_temp;
  logic              in_fault;

  // Result register.
  logic              out_valid;
  logic              out_fan_on;
  logic [DUTY_W-1:0] out_duty;
  logic              out_alarm;

  logic              advance;
  logic [EXT_W-1:0]  temp_ext;
  logic [EXT_W-1:0]  temp_hyst;
  logic [CMP_W-1:0]  count_ext;
  logic [CMP_W-1:0]  duty_ext;

  assign cfg.ready  = 1'b1;
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  assign result.valid    = out_valid;
  assign result.fan_on   = out_fan_on;
  assign result.duty_now = out_duty;
  assign result.alarm_on = out_alarm;

  always_ff @(posedge clk) begin
    if (rst) begin
      band1_temp <= BAND1_TEMP_RST;
      band2_temp <= BAND2_TEMP_RST;
      band3_temp <= BAND3_TEMP_RST;
      alarm_temp <= ALARM_TEMP_RST;
      band1_duty <= BAND1_DUTY_RST;
      band2_duty <= BAND2_DUTY_RST;
      band3_duty <= BAND3_DUTY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BAND1_TEMP: band1_temp <= cfg.data;
        REG_BAND2_TEMP: band2_temp <= cfg.data;
        REG_BAND3_TEMP: band3_temp <= cfg.data;
        REG_ALARM_TEMP: alarm_temp <= cfg.data;
        REG_BAND1_DUTY: band1_duty <= cfg.data[DUTY_W-1:0];
        REG_BAND2_DUTY: band2_duty <= cfg.data[DUTY_W-1:0];
        REG_BAND3_DUTY: band3_duty <= cfg.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // "temp < threshold - 2" is evaluated as "temp + 2 < threshold" so that it never wraps.
  assign temp_ext  = {1'b0, in_temp};
  assign temp_hyst = temp_ext + EXT_W'(HYST);
  assign count_ext = CMP_W'(pwm_count);
  assign duty_ext  = CMP_W'(duty_level);

  always_comb begin
    band_duty_next   = band_duty;
    fan_running_next = fan_running;
    duty_level_next  = duty_level;
    pwm_count_next   = pwm_count;
    alarm_flag_next  = alarm_flag;
    fan_level_next   = fan_level;
    if (in_op == OP_TICK) begin
      if (duty_level == '0) begin
        fan_level_next = 1'b0;
      end else if (duty_ext == CMP_W'(PWM_PERIOD)) begin
        fan_level_next = 1'b1;
      end else begin
        fan_level_next = (count_ext <= duty_ext);
      end
      if (pwm_count == CNT_W'(PWM_PERIOD - 1)) begin
        pwm_count_next = '0;
      end else begin
        pwm_count_next = pwm_count + CNT_W'(1);
      end
    end else if (in_fault) begin
      duty_level_next = FAULT_DUTY;
      alarm_flag_next = 1'b0;
    end else begin
      alarm_flag_next = 1'b0;
      if (in_temp >= band1_temp) begin
        if (in_temp < band2_temp) begin
          if (band_duty != band2_duty || temp_hyst < {1'b0, band2_temp}) begin
            band_duty_next = band1_duty;
          end
        end else if (in_temp < band3_temp) begin
          if (band_duty != band3_duty || temp_hyst < {1'b0, band3_temp}) begin
            band_duty_next = band2_duty;
          end
        end else begin
          band_duty_next  = band3_duty;
          alarm_flag_next = (in_temp > alarm_temp);
        end
        if (!fan_running) begin
          duty_level_next  = KICK_DUTY;
          fan_running_next = 1'b1;
        end else begin
          duty_level_next = band_duty_next;
        end
      end else if (temp_hyst < {1'b0, band1_temp}) begin
        duty_level_next  = '0;
        fan_running_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      band_duty   <= '0;
      fan_running <= 1'b0;
      duty_level  <= '0;
      pwm_count   <= '0;
      alarm_flag  <= 1'b0;
      fan_level   <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        band_duty   <= band_duty_next;
        fan_running <= fan_running_next;
        duty_level  <= duty_level_next;
        pwm_count   <= pwm_count_next;
        alarm_flag  <= alarm_flag_next;
        fan_level   <= fan_level_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_op    <= item.op;
      in_temp  <= item.temp_reading;
      in_fault <= item.sensor_fault;
    end
    if (advance) begin
      out_fan_on <= fan_level_next;
      out_duty   <= duty_level_next;
      out_alarm  <= alarm_flag_next;
    end
  end

endmodule

@@ sv/sfsc_checker.sv @@
`include "assert_macros.svh"

module sfsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic                      result_fan_on,
  input logic [sfsc_pkg::DUTY_W-1:0] result_duty_now,
  input logic                      result_alarm_on
);
  import sfsc_pkg::*;

  logic item_acc;
  assign item_acc = item_valid && item_ready;

  // The input side is open straight after reset.
  `SFSC_ASSERT_ALWAYS(a_ready_after_rst, rst |=> item_ready, "item not ready after reset")

  // With no result pending the input register can always move on.
  `SFSC_ASSERT(a_ready_when_empty, !result_valid |-> item_ready, "item stalled with empty output")

  // An accepted request is followed by a valid result.
  `SFSC_ASSERT(a_result_latency, item_acc |-> ##2 result_valid, "result missing after request")

  `SFSC_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result_fan_on) && $stable(result_duty_now) && $stable(result_alarm_on), "stalled result changed")

endmodule

bind stepped_fan_speed_controller_core sfsc_checker u_sfsc_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_fan_on   (result.fan_on),
  .result_duty_now (result.duty_now),
  .result_alarm_on (result.alarm_on)
);

@@ test/stepped_fan_speed_controller_core_test.sv @@
`timescale 1ns / 100ps

module stepped_fan_speed_controller_core_test;
  import sfsc_pkg::*;

  localparam int RESET_CYCLES     = 11;
  localparam int PWM_STEPS        = PWM_PERIOD_DEF;
  localparam int PHASES           = 7;
  localparam int PRESSURE_PHASE   = 4;
  localparam int RANDOM_PER_PHASE = 95;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_TAIL       = 8;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DIRECTED_ROWS    = 25;

  // Index beyond the register list; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic              fan_on;
    logic [DUTY_W-1:0] duty_now;
    logic              alarm_on;
  } fan_status_t;

  typedef struct packed {
    logic        typed;
    fan_status_t fixed;
  } pending_check_t;

  typedef struct packed {
    logic              op;
    logic [TEMP_W-1:0] temp;
    logic              fault;
    logic              typed;
    fan_status_t       fixed;
  } directed_row_t;

  logic clk;
  logic rst;

  sfsc_cfg_if    cfg_bus ();
  sfsc_item_if   item_bus ();
  sfsc_result_if result_bus ();

  stepped_fan_speed_controller_core uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  // Directed requests at the reset settings. Rows with typed set carry the
  // expected result; the rest are checked against the predictor.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_TICK,   8'd0,   1'b0, 1'b1, '{1'b0, 6'd0,  1'b0}},
    '{OP_SAMPLE, 8'd0,   1'b0, 1'b1, '{1'b0, 6'd0,  1'b0}},
    '{OP_SAMPLE, 8'd255, 1'b1, 1'b1, '{1'b0, 6'd49, 1'b0}},
    '{OP_SAMPLE, 8'd30,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd30,  1'b0, 1'b0, '0},
    '{OP_TICK,   8'd0,   1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd45,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd43,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd42,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd60,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd58,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd76,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd75,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd255, 1'b0, 1'b0, '0},
    '{OP_TICK,   8'd0,   1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd28,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd27,  1'b0, 1'b0, '0},
    '{OP_TICK,   8'd0,   1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd100, 1'b1, 1'b0, '0},
    '{OP_SAMPLE, 8'd50,  1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd50,  1'b0, 1'b0, '0},
    '{OP_TICK,   8'd255, 1'b1, 1'b0, '0},
    '{OP_TICK,   8'd170, 1'b0, 1'b0, '0},
    '{OP_SAMPLE, 8'd85,  1'b1, 1'b0, '0},
    '{OP_TICK,   8'd85,  1'b1, 1'b0, '0}
  };

  // Predictor copy of the registers and the controller state.
  logic [7:0] cfg_reg [0:6] = '{BAND1_TEMP_RST, BAND2_TEMP_RST, BAND3_TEMP_RST,
                                ALARM_TEMP_RST, 8'(BAND1_DUTY_RST), 8'(BAND2_DUTY_RST),
                                8'(BAND3_DUTY_RST)};
  logic [DUTY_W-1:0] band_duty   = '0;
  logic              fan_running = 1'b0;
  logic [DUTY_W-1:0] duty_level  = '0;
  int                pwm_count   = 0;
  logic              alarm_flag  = 1'b0;
  logic              fan_level   = 1'b0;

  fan_status_t    status_q [$];
  pending_check_t request_q [$];

  int mismatch_count = 0;
  int result_count   = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic fan_status_t advance_controller(input logic op,
                                                     input logic [TEMP_W-1:0] temp,
                                                     input logic fault);
    int t, t1, t2, t3, t4;
    t  = int'(temp);
    t1 = int'(cfg_reg[REG_BAND1_TEMP]);
    t2 = int'(cfg_reg[REG_BAND2_TEMP]);
    t3 = int'(cfg_reg[REG_BAND3_TEMP]);
    t4 = int'(cfg_reg[REG_ALARM_TEMP]);
    if (op == OP_TICK) begin
      if (duty_level == 0)
        fan_level = 1'b0;
      else if (duty_level == PWM_STEPS)
        fan_level = 1'b1;
      else
        fan_level = (pwm_count <= duty_level);
      pwm_count = (pwm_count + 1 >= PWM_STEPS) ? 0 : pwm_count + 1;
    end else if (fault) begin
      duty_level = FAULT_DUTY;
      alarm_flag = 1'b0;
    end else begin
      alarm_flag = 1'b0;
      if (t >= t1) begin
        // Stepping down out of a higher band needs a further HYST degrees.
        if (t < t2) begin
          if (band_duty != cfg_reg[REG_BAND2_DUTY][DUTY_W-1:0] || t < t2 - HYST)
            band_duty = cfg_reg[REG_BAND1_DUTY][DUTY_W-1:0];
        end else if (t < t3) begin
          if (band_duty != cfg_reg[REG_BAND3_DUTY][DUTY_W-1:0] || t < t3 - HYST)
            band_duty = cfg_reg[REG_BAND2_DUTY][DUTY_W-1:0];
        end else begin
          band_duty = cfg_reg[REG_BAND3_DUTY][DUTY_W-1:0];
          if (t > t4)
            alarm_flag = 1'b1;
        end
        if (!fan_running) begin
          duty_level  = KICK_DUTY;
          fan_running = 1'b1;
        end else begin
          duty_level = band_duty;
        end
      end else if (t < t1 - HYST) begin
        duty_level  = '0;
        fan_running = 1'b0;
      end
    end
    return '{fan_level, duty_level, alarm_flag};
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("result %0d: %s is %0d, expected %0d", result_count, what, got_v, want_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    fan_status_t    got, want;
    pending_check_t row;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready && cfg_bus.index <= REG_BAND3_DUTY) begin
        if (cfg_bus.index >= REG_BAND1_DUTY)
          cfg_reg[cfg_bus.index] = {2'b00, cfg_bus.data[DUTY_W-1:0]};
        else
          cfg_reg[cfg_bus.index] = cfg_bus.data;
      end
      if (result_bus.valid && result_bus.ready) begin
        got = '{result_bus.fan_on, result_bus.duty_now, result_bus.alarm_on};
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result, duty_now", int'(got.duty_now), 0);
        end else begin
          want = status_q.pop_front();
          if (got.fan_on !== want.fan_on)
            report_mismatch("fan_on", int'(got.fan_on), int'(want.fan_on));
          if (got.duty_now !== want.duty_now)
            report_mismatch("duty_now", int'(got.duty_now), int'(want.duty_now));
          if (got.alarm_on !== want.alarm_on)
            report_mismatch("alarm_on", int'(got.alarm_on), int'(want.alarm_on));
        end
        result_count++;
      end
      if (item_bus.valid && item_bus.ready) begin
        want = advance_controller(item_bus.op, item_bus.temp_reading, item_bus.sensor_fault);
        row  = request_q.pop_front();
        status_q.push_back(row.typed ? row.fixed : want);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("stepped_fan_speed_controller_core: mismatch");
    $finish;
  end

  task automatic offer(input logic op, input logic [TEMP_W-1:0] temp, input logic fault,
                       input pending_check_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    request_q.push_back(row);
    item_bus.valid        <= 1'b1;
    item_bus.op           <= op;
    item_bus.temp_reading <= temp;
    item_bus.sensor_fault <= fault;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  task automatic offer_random();
    logic              op;
    logic [TEMP_W-1:0] temp;
    logic              fault;
    int                t;
    op    = ($urandom_range(99) < 50) ? OP_TICK : OP_SAMPLE;
    temp  = TEMP_W'($urandom_range(255));
    fault = ($urandom_range(99) < 6);
    // Most samples sit close to a threshold so that the hysteresis is exercised.
    if (op == OP_SAMPLE && $urandom_range(99) < 65) begin
      t = cfg_reg[$urandom_range(REG_BAND1_TEMP, REG_ALARM_TEMP)] + $urandom_range(8) - 4;
      temp = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : t[TEMP_W-1:0];
    end
    offer(op, temp, fault, '0);
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic apply_setting(input int phase);
    logic [7:0] s [0:6];
    case (phase)
      1: s = '{default: 8'h00};
      2: s = '{default: 8'hFF};
      3: s = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd50, 8'd50, 8'd50};
      4: s = '{8'd20, 8'd40, 8'd60, 8'd80, 8'd50, 8'd1, 8'd49};
      5: begin
        s[REG_BAND1_TEMP] = 8'($urandom_range(120));
        s[REG_BAND2_TEMP] = 8'(s[REG_BAND1_TEMP] + $urandom_range(60));
        s[REG_BAND3_TEMP] = 8'(s[REG_BAND2_TEMP] + $urandom_range(60));
        s[REG_ALARM_TEMP] = 8'(s[REG_BAND3_TEMP] + $urandom_range(15));
        s[REG_BAND1_DUTY] = 8'($urandom_range(50));
        s[REG_BAND2_DUTY] = 8'($urandom_range(50));
        s[REG_BAND3_DUTY] = 8'($urandom_range(50));
      end
      default: foreach (s[i]) s[i] = 8'($urandom_range(255));
    endcase
    for (int i = REG_BAND1_TEMP; i <= REG_BAND3_DUTY; i++)
      write_reg(CFG_IDX_W'(i), s[i]);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(255)));
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    rst                   <= 1'b1;
    item_bus.valid        <= 1'b0;
    item_bus.op           <= OP_TICK;
    item_bus.temp_reading <= '0;
    item_bus.sensor_fault <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= REG_BAND1_TEMP;
    cfg_bus.data          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (phase == 0) begin
        foreach (directed_rows[i])
          offer(directed_rows[i].op, directed_rows[i].temp, directed_rows[i].fault,
                '{directed_rows[i].typed, directed_rows[i].fixed});
      end else begin
        drain();
        apply_setting(phase);
      end
      // The result side holds off while requests keep coming, so the block backs up.
      if (phase == PRESSURE_PHASE)
        hold_left = HOLD_CYCLES;
      repeat (RANDOM_PER_PHASE) offer_random();
    end

    drain();
    if (mismatch_count == 0 && status_q.size() == 0)
      $display("stepped_fan_speed_controller_core: match");
    else
      $display("stepped_fan_speed_controller_core: mismatch");
    $finish;
  end

endmodule
